### rtl/spp_pkg.sv
// shared types, constants and the fixed sprite records for the projector
`default_nettype none
package spp_pkg;

  localparam logic [2:0] IDX_TABLE    = 3'd0;
  localparam logic [2:0] IDX_NET      = 3'd1;
  localparam logic [2:0] IDX_PLAYER   = 3'd2;
  localparam logic [2:0] IDX_OPPONENT = 3'd3;
  localparam logic [2:0] IDX_BALL     = 3'd4;

  localparam logic [2:0] REG_BALL_SCALE   = 3'd0;
  localparam logic [2:0] REG_BALL_SHIFT   = 3'd1;
  localparam logic [2:0] REG_PADDLE_SCALE = 3'd2;
  localparam logic [2:0] REG_PADDLE_SHIFT = 3'd3;
  localparam logic [2:0] REG_THRESHOLD    = 3'd4;

  // q16 camera coefficients
  localparam logic signed [17:0] C_SIN  = 18'sd14025;
  localparam logic signed [17:0] C_COS  = 18'sd64029;
  localparam logic signed [31:0] C_OFSY = 32'sd72993997;
  localparam logic signed [31:0] C_OFSZ = 32'sd156899738;
  localparam logic signed [10:0] C_FOCAL = 11'sd879;

  // screen centre
  localparam logic signed [9:0] C_CX = 10'sd160;
  localparam logic signed [9:0] C_CY = 10'sd120;

  localparam int QW = 48;  // not used; the perspective divide quotient is NW wide
  localparam int NW = 64;  // numerator width

  localparam logic [15:0] FIX_DEPTH = 16'd450;
  localparam logic [15:0] FIX_X     = 16'd11;
  localparam logic [15:0] FIX_Y     = 16'd98;
  localparam logic [15:0] FIX_SIZE  = 16'd97;

  typedef struct packed {
    logic        visible;
    logic [2:0]  sprite_index;
    logic [15:0] depth;
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic [15:0] sprite_size;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [7:0] scale;
    logic [4:0] shift;
  } size_cfg_t;

endpackage
`default_nettype wire

### rtl/spp_divider.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module spp_divider
  import spp_pkg::*;
#(
  parameter int NUM_W = 64,
  parameter int DEN_W = 40,
  parameter int TAG_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [TAG_W-1:0]  in_tag,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       quo,
  output logic [TAG_W-1:0]       out_tag
);

  logic [NUM_W:0]       vld;
  logic [NUM_W-1:0]     q   [NUM_W+1];
  logic [DEN_W:0]       rem [NUM_W+1];
  logic [DEN_W-1:0]     dv  [NUM_W+1];
  logic [TAG_W-1:0]     tg  [NUM_W+1];

  always_comb begin
    vld[0] = in_valid;
    q[0]   = num;
    rem[0] = '0;
    dv[0]  = den;
    tg[0]  = in_tag;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   shl;
    assign shl   = {rem[s][DEN_W-1:0], q[s][NUM_W-1]};
    assign trial = {1'b0, shl} - {2'b00, dv[s]};
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
      dv[s+1] <= dv[s];
      tg[s+1] <= tg[s];
      if (!trial[DEN_W+1]) begin
        rem[s+1] <= trial[DEN_W:0];
        q[s+1]   <= {q[s][NUM_W-2:0], 1'b1};
      end else begin
        rem[s+1] <= shl;
        q[s+1]   <= {q[s][NUM_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[NUM_W];
  assign quo       = q[NUM_W];
  assign out_tag   = tg[NUM_W];

endmodule
`default_nettype wire

### rtl/spp_object.sv
// one object lane: camera transform, perspective divides, size divide, record
`default_nettype none
module spp_object
  import spp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [15:0] z,
  input  wire size_cfg_t          cfg,
  input  wire logic [2:0]         idx,
  output logic                    out_valid,
  output rec_t                    rec
);

  // stage 1: products
  logic               v1;
  logic signed [33:0] py1, pz1, py2, pz2;
  logic signed [15:0] x1;
  size_cfg_t          cfg1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    py1 <= 34'(y * C_SIN);
    pz1 <= 34'(z * C_COS);
    py2 <= 34'(y * C_COS);
    pz2 <= 34'(z * C_SIN);
    x1  <= x;
    cfg1 <= cfg;
  end

  // stage 2: camera coordinates
  logic               v2;
  logic signed [34:0] cy2, cz2;
  logic signed [15:0] x2;
  size_cfg_t          cfg2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    cy2 <= 35'(py1) + 35'(pz1) - 35'(C_OFSY);
    cz2 <= 35'(py2) - 35'(pz2) + 35'(C_OFSZ);
    x2  <= x1;
    cfg2 <= cfg1;
  end

  // stage 3: numerators with the centre folded in, depth
  logic               v3;
  logic signed [NW-1:0] nx3, ny3;
  logic signed [35:0] den3;
  logic [15:0]        depth3;
  size_cfg_t          cfg3;
  logic signed [34:0] czt;
  always_comb czt = (cz2 < 0) ? -((-cz2) >>> 16) : (cz2 >>> 16);
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    nx3 <= (NW'(NW'(C_FOCAL) * NW'(x2)) <<< 16) + NW'(NW'(2 * C_CX) * NW'(cz2));
    ny3 <= NW'(NW'(2 * C_CY) * NW'(cz2)) - NW'(NW'(C_FOCAL) * NW'(cy2));
    den3 <= 36'(cz2) <<< 1;
    depth3 <= 16'(czt >>> 3);
    cfg3 <= cfg2;
  end

  // stage 4: magnitudes and size operands for the unsigned dividers
  logic               v4;
  logic [NW-1:0]      ax4, ay4;
  logic [35:0]        ad4;
  logic               sx4, sy4, zx4, zy4, dz4, nxs4, nys4;
  logic [15:0]        depth4;
  logic [NW-1:0]      sn4;
  logic [23:0]        sd4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    ax4 <= nx3[NW-1] ? -nx3 : nx3;
    ay4 <= ny3[NW-1] ? -ny3 : ny3;
    ad4 <= den3[35] ? -den3 : den3;
    sx4 <= nx3[NW-1] ^ den3[35];
    sy4 <= ny3[NW-1] ^ den3[35];
    zx4 <= (nx3 == 0);
    zy4 <= (ny3 == 0);
    dz4 <= (den3 == 0);
    nxs4 <= nx3[NW-1];
    nys4 <= ny3[NW-1];
    depth4 <= depth3;
    sn4 <= NW'(64'd32 << cfg3.shift);
    sd4 <= depth3 * cfg3.scale;
  end

  // three dividers run in lockstep; side data rides on the tag
  localparam int TW = 1 + 1 + 1 + 1 + 1 + 1 + 16 + 1 + 1;
  logic [TW-1:0] tag_in, tag_out;
  assign tag_in = {sx4, sy4, zx4, zy4, dz4, (sd4 == 0), depth4, nxs4, nys4};
  logic          dv_x, dv_y, dv_s;
  logic [NW-1:0] qx, qy, qs;
  logic [TW-1:0] tg_y, tg_s;

  spp_divider #(.NUM_W(NW), .DEN_W(36), .TAG_W(TW)) u_divx (
    .clk, .rst, .in_valid(v4), .num(ax4), .den(ad4), .in_tag(tag_in),
    .out_valid(dv_x), .quo(qx), .out_tag(tag_out));
  spp_divider #(.NUM_W(NW), .DEN_W(36), .TAG_W(TW)) u_divy (
    .clk, .rst, .in_valid(v4), .num(ay4), .den(ad4), .in_tag(tag_in),
    .out_valid(dv_y), .quo(qy), .out_tag(tg_y));
  spp_divider #(.NUM_W(NW), .DEN_W(24), .TAG_W(TW)) u_divs (
    .clk, .rst, .in_valid(v4), .num(sn4), .den(sd4), .in_tag(tag_in),
    .out_valid(dv_s), .quo(qs), .out_tag(tg_s));

  // stage 5: signed quotients, size saturate
  logic               v5;
  logic signed [NW:0] col5, row5;
  logic [15:0]        size5, depth5;
  logic               sgx, sgy, zx, zy, dz, szz, nxs, nys;
  logic [15:0]        dpt;
  assign {sgx, sgy, zx, zy, dz, szz, dpt, nxs, nys} = tag_out;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= dv_x & dv_y & dv_s;
    if (dz) begin
      col5 <= zx ? (NW+1)'(C_CX) : (nxs ? -(NW+1)'(32768) : (NW+1)'(32767));
      row5 <= zy ? (NW+1)'(C_CY) : (nys ? -(NW+1)'(32768) : (NW+1)'(32767));
    end else begin
      col5 <= sgx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      row5 <= sgy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
    size5 <= (szz || qs > NW'(16'hFFFF)) ? 16'hFFFF : qs[15:0];
    depth5 <= dpt;
  end

  // stage 6: offset and saturate
  logic signed [NW+1:0] ex, ey;
  assign ex = (NW+2)'(col5) - (NW+2)'(size5 >> 1);
  assign ey = (NW+2)'(row5) - (NW+2)'(size5 >> 1);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v5;
    rec.visible      <= 1'b1;
    rec.sprite_index <= idx;
    rec.depth        <= depth5;
    rec.screen_x <= (ex > 32767) ? 16'h7FFF : (ex < -32768) ? 16'h8000 : ex[15:0];
    rec.screen_y <= (ey > 32767) ? 16'h7FFF : (ey < -32768) ? 16'h8000 : ey[15:0];
    rec.sprite_size  <= size5;
    rec.last         <= 1'b0;
  end

endmodule
`default_nettype wire

### rtl/spp_sequencer.sv
// buffers finished frames and plays out five records in draw order
`default_nettype none
module spp_sequencer
  import spp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic ball_first,
  input  wire rec_t opp,
  input  wire rec_t ball,
  input  wire rec_t ply,
  output logic      strobe,
  output rec_t      rec,
  output logic      full
);

  // two-frame buffer
  logic [1:0] cnt;
  logic       rd, wr;
  rec_t       bo [2], bb [2], bp [2];
  logic       bf [2];
  logic [2:0] phase;
  logic       busy;

  assign full = in_valid && (cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (in_valid) begin
      bo[wr] <= opp;
      bb[wr] <= ball;
      bp[wr] <= ply;
      bf[wr] <= ball_first;
    end
  end

  rec_t tbl;
  always_comb begin
    tbl = '{1'b1, IDX_TABLE, FIX_DEPTH, FIX_X, FIX_Y, FIX_SIZE, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; wr <= 1'b0; phase <= '0; busy <= 1'b0;
      strobe <= 1'b0;
    end else begin
      logic take;
      rec_t tail;
      take = !busy && (cnt != 0);
      tail = bp[rd];
      tail.last = 1'b1;
      if (in_valid) wr <= ~wr;
      strobe <= busy || take;
      if (take) begin
        busy  <= 1'b1;
        phase <= 3'd1;
        rec   <= '{1'b0, IDX_NET, FIX_DEPTH, FIX_X, FIX_Y, FIX_SIZE, 1'b0};
      end else if (busy) begin
        case (phase)
          3'd1: rec <= bo[rd];
          3'd2: rec <= bf[rd] ? bb[rd] : tbl;
          3'd3: rec <= bf[rd] ? tbl : bb[rd];
          default: rec <= tail;
        endcase
        phase <= phase + 3'd1;
        if (phase == 3'd4) begin
          busy <= 1'b0;
          rd   <= ~rd;
        end
      end
      cnt <= cnt + (in_valid ? 2'd1 : 2'd0) - ((busy && phase == 3'd4) ? 2'd1 : 2'd0);
    end
  end

endmodule
`default_nettype wire

### rtl/sprite_perspective_projector_unit.sv
// top level: config registers, three object lanes and the record sequencer
// A frame is taken whenever busy is low; busy rises after each accepted frame
// and stays high while the hold counter runs down. Each frame yields five
// strobed records (net, opponent, ball/table by the y threshold, player) on
// consecutive cycles, once it has passed the object lanes with their 64-stage
// bit-per-stage dividers. Results cannot be held off.
`default_nettype none
module sprite_perspective_projector_unit
  import spp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [15:0] ball_x,
  input  wire logic signed [15:0] ball_y,
  input  wire logic signed [15:0] ball_z,
  input  wire logic signed [15:0] player_x,
  input  wire logic signed [15:0] player_y,
  input  wire logic signed [15:0] player_z,
  input  wire logic signed [15:0] opponent_x,
  input  wire logic signed [15:0] opponent_y,
  input  wire logic signed [15:0] opponent_z,
  output logic                    strobe,
  output logic                    visible,
  output logic [2:0]              sprite_index,
  output logic [15:0]             depth,
  output logic signed [15:0]      screen_x,
  output logic signed [15:0]      screen_y,
  output logic [15:0]             sprite_size,
  output logic                    last
);

  size_cfg_t          ball_cfg, pad_cfg;
  logic signed [15:0] thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      ball_cfg <= '{8'd24, 5'd11};
      pad_cfg  <= '{8'd26, 5'd13};
      thresh   <= 16'sd2740;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BALL_SCALE:   ball_cfg.scale <= cfg_data[7:0];
        REG_BALL_SHIFT:   ball_cfg.shift <= cfg_data[4:0];
        REG_PADDLE_SCALE: pad_cfg.scale  <= cfg_data[7:0];
        REG_PADDLE_SHIFT: pad_cfg.shift  <= cfg_data[4:0];
        REG_THRESHOLD:    thresh         <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       accept;
  logic [2:0] hold;
  assign accept = start && !busy;
  assign busy   = (hold != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) hold <= '0;
    else if (accept) hold <= 3'd4;
    else if (hold != 0) hold <= hold - 3'd1;
  end

  // ball-first flag travels alongside the lane pipelines
  localparam int LAT = 6 + NW;
  logic [LAT-1:0] bf_sr;
  always_ff @(posedge clk) bf_sr <= {bf_sr[LAT-2:0], ball_y > thresh};

  logic vo, vb, vp;
  rec_t ro, rb, rp;

  spp_object u_opp (.clk, .rst, .in_valid(accept), .x(opponent_x), .y(opponent_y),
    .z(opponent_z), .cfg(pad_cfg), .idx(IDX_OPPONENT), .out_valid(vo), .rec(ro));
  spp_object u_ball (.clk, .rst, .in_valid(accept), .x(ball_x), .y(ball_y),
    .z(ball_z), .cfg(ball_cfg), .idx(IDX_BALL), .out_valid(vb), .rec(rb));
  spp_object u_ply (.clk, .rst, .in_valid(accept), .x(player_x), .y(player_y),
    .z(player_z), .cfg(pad_cfg), .idx(IDX_PLAYER), .out_valid(vp), .rec(rp));

  rec_t r;
  logic full;
  spp_sequencer u_seq (.clk, .rst, .in_valid(vo), .ball_first(bf_sr[LAT-1]),
    .opp(ro), .ball(rb), .ply(rp), .strobe, .rec(r), .full);

  assign visible      = r.visible;
  assign sprite_index = r.sprite_index;
  assign depth        = r.depth;
  assign screen_x     = r.screen_x;
  assign screen_y     = r.screen_y;
  assign sprite_size  = r.sprite_size;
  assign last         = r.last;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (vo == vb) && (vo == vp)) else $error("object lanes out of step");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !full) else $error("frame buffer overflow");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("busy not raised after accept");

endmodule
`default_nettype wire
